@@ rtl/core/lowest_free_slot_allocator_top_assert.svh @@
// assertion helpers for the slot allocator, clocked on clock, off during reset
`ifndef LOWEST_FREE_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define LOWEST_FREE_SLOT_ALLOCATOR_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define LFSA_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define LFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/lfsa_pkg.sv @@
`default_nettype none

package lfsa_pkg;

   localparam int NUM_SLOTS  = 64;
   localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int SLOT_OUT_W = 6;
   localparam int REQ_W      = 16;
   localparam int TIME_W     = 32;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRIME,
      ST_SCAN,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture the request fields
      logic addr_clr;   // restart the scan at slot zero
      logic addr_inc;   // step the read address
      logic grant;      // store leave time in the compared slot
      logic full;       // record a result with no free slot
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic hit;        // compared slot is free
      logic last;       // compared slot is the highest one
   } dp_sts_type;

   // low bits of a slot number in the result field width
   function automatic logic [SLOT_OUT_W-1:0] slot_field(input logic [SLOT_W-1:0] idx);
      logic [SLOT_W+SLOT_OUT_W-1:0] wide;
      wide = {{SLOT_OUT_W{1'b0}}, idx};
      return wide[SLOT_OUT_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/lfsa_ram.sv @@
`default_nettype none

module lfsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                       wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ rtl/core/lfsa_dp.sv @@
`default_nettype none

module lfsa_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire lfsa_pkg::dp_cmd_type              cmd,
   output lfsa_pkg::dp_sts_type                   sts,
   input  wire logic [lfsa_pkg::REQ_W-1:0]        req_requester,
   input  wire logic [lfsa_pkg::TIME_W-1:0]       req_arrive_time,
   input  wire logic [lfsa_pkg::TIME_W-1:0]       req_leave_time,
   input  wire logic                              csr_we,
   input  wire logic [lfsa_pkg::REQ_W-1:0]        csr_wdata,
   output logic      [lfsa_pkg::SLOT_OUT_W-1:0]   rsp_slot,
   output logic                                   rsp_is_target,
   output logic                                   rsp_full_res
);

   import lfsa_pkg::*;

   logic [REQ_W-1:0]      target_ff,  target_in;
   logic [REQ_W-1:0]      req_ff,     req_in;
   logic [TIME_W-1:0]     arrive_ff,  arrive_in;
   logic [TIME_W-1:0]     leave_ff,   leave_in;
   logic [SLOT_W-1:0]     rd_addr_ff, rd_addr_in;
   logic [SLOT_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic [NUM_SLOTS-1:0]  slot_vld_ff, slot_vld_in;
   logic [SLOT_OUT_W-1:0] slot_ff,    slot_in;
   logic                  tgt_ff,     tgt_in;
   logic                  full_ff,    full_in;
   logic [TIME_W-1:0]     rd_data;
   logic [TIME_W-1:0]     rel_time;

   lfsa_ram #(
      .WIDTH (TIME_W),
      .DEPTH (NUM_SLOTS)
   ) u_rel_ram (
      .clock (clock),
      .we    (cmd.grant),
      .waddr (cmp_idx_ff),
      .wdata (leave_ff),
      .raddr (rd_addr_ff),
      .rdata (rd_data)
   );

   // never-written slots read as released at time zero
   assign rel_time = cmp_vld_ff ? rd_data : '0;

   always_comb begin
      sts.hit  = (rel_time <= arrive_ff);
      sts.last = (cmp_idx_ff == LAST_SLOT);
   end

   always_comb begin
      target_in   = csr_we ? csr_wdata : target_ff;
      req_in      = cmd.load ? req_requester   : req_ff;
      arrive_in   = cmd.load ? req_arrive_time : arrive_ff;
      leave_in    = cmd.load ? req_leave_time  : leave_ff;
      rd_addr_in  = rd_addr_ff;
      if (cmd.addr_clr) begin
         rd_addr_in = '0;
      end else if (cmd.addr_inc && (rd_addr_ff != LAST_SLOT)) begin
         rd_addr_in = rd_addr_ff + SLOT_W'(1);
      end
      cmp_idx_in  = rd_addr_ff;
      cmp_vld_in  = slot_vld_ff[rd_addr_ff];
      slot_vld_in = slot_vld_ff;
      if (cmd.grant) begin
         slot_vld_in[cmp_idx_ff] = 1'b1;
      end
      slot_in = slot_ff;
      tgt_in  = tgt_ff;
      full_in = full_ff;
      if (cmd.grant || cmd.full) begin
         slot_in = cmd.grant ? slot_field(cmp_idx_ff) : '0;
         tgt_in  = (req_ff == target_ff);
         full_in = cmd.full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= '0;
         slot_vld_ff <= '0;
      end else begin
         target_ff   <= target_in;
         slot_vld_ff <= slot_vld_in;
      end
      req_ff     <= req_in;
      arrive_ff  <= arrive_in;
      leave_ff   <= leave_in;
      rd_addr_ff <= rd_addr_in;
      cmp_idx_ff <= cmp_idx_in;
      cmp_vld_ff <= cmp_vld_in;
      slot_ff    <= slot_in;
      tgt_ff     <= tgt_in;
      full_ff    <= full_in;
   end

   assign rsp_slot      = slot_ff;
   assign rsp_is_target = tgt_ff;
   assign rsp_full_res  = full_ff;

endmodule

`default_nettype wire

@@ rtl/core/lfsa_ctrl.sv @@
`default_nettype none

module lfsa_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   output logic                        rsp_valid,
   output lfsa_pkg::dp_cmd_type        cmd,
   input  wire lfsa_pkg::dp_sts_type   sts
);

   import lfsa_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load     = 1'b1;
               cmd.addr_clr = 1'b1;
               state_in     = ST_PRIME;
            end
         end
         ST_PRIME: begin
            cmd.addr_inc = 1'b1;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.addr_inc = 1'b1;
            if (sts.hit) begin
               cmd.grant = 1'b1;
               state_in  = ST_RESP;
            end else if (sts.last) begin
               cmd.full = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/core/lowest_free_slot_allocator_top.sv @@
// channel    direction  transfer when        payload
// request    in         start && !busy       req_requester, req_arrive_time, req_leave_time
// response   out        rsp_valid            rsp_slot, rsp_is_target, rsp_full_res
// csr        in         csr_we               csr_wdata (target requester)
//
// a request granted slot s passes through the prime state, then the scan from slot zero up to s,
// then raises its response strobe; busy drops the cycle after the strobe,
// and when every slot is taken the scan runs up to the highest slot before the full response
// the scan uses one read port on the release-time ram and compares one slot per cycle
// synchronous active-high reset: all slots free and target requester zero, no clearing pass
// the response sits on the ports for exactly one cycle and cannot be stalled
`default_nettype none

`include "lowest_free_slot_allocator_top_assert.svh"

module lowest_free_slot_allocator_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [lfsa_pkg::REQ_W-1:0]        req_requester,
   input  wire logic [lfsa_pkg::TIME_W-1:0]       req_arrive_time,
   input  wire logic [lfsa_pkg::TIME_W-1:0]       req_leave_time,
   // response channel
   output logic                                   rsp_valid,
   output logic      [lfsa_pkg::SLOT_OUT_W-1:0]   rsp_slot,
   output logic                                   rsp_is_target,
   output logic                                   rsp_full_res,
   // target requester register
   input  wire logic                              csr_we,
   input  wire logic [lfsa_pkg::REQ_W-1:0]        csr_wdata
);

   import lfsa_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // sequencer: idle, prime the ram read, scan slots, present the response
   lfsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   // release-time ram with per-slot written bits, compare and response registers
   lfsa_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_requester   (req_requester),
      .req_arrive_time (req_arrive_time),
      .req_leave_time  (req_leave_time),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .rsp_slot        (rsp_slot),
      .rsp_is_target   (rsp_is_target),
      .rsp_full_res    (rsp_full_res)
   );

   // a response is a single-cycle pulse
   `LFSA_ASSERT_NEXT(a_rsp_pulse, rsp_valid, !rsp_valid, "response held longer than one cycle")

   // a full response never carries a slot number
   `LFSA_ASSERT_SAME(a_full_slot, rsp_valid && rsp_full_res, rsp_slot == '0, "full response with nonzero slot")

   // an accepted request keeps the block busy
   `LFSA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but block not busy")

   // the scan ends either in a grant or in full, never both
   `LFSA_ASSERT_SAME(a_grant_full, cmd.grant, !cmd.full, "grant and full in the same cycle")

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import lfsa_pkg::*;

   // run limit in clock cycles
   localparam int CYCLE_LIMIT = 400000;

   // one predicted grant, field for field as it appears on the response ports
   typedef struct {
      logic [SLOT_OUT_W-1:0] slot;
      logic                  is_target;
      logic                  full_res;
   } grant_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [REQ_W-1:0]  req_requester   = '0;
   logic [TIME_W-1:0] req_arrive_time = '0;
   logic [TIME_W-1:0] req_leave_time  = '0;
   logic                  rsp_valid;
   logic [SLOT_OUT_W-1:0] rsp_slot;
   logic                  rsp_is_target;
   logic                  rsp_full_res;
   logic              csr_we    = 1'b0;
   logic [REQ_W-1:0]  csr_wdata = '0;

   // predictor state: release time per slot and the target requester
   logic [TIME_W-1:0] slot_release [NUM_SLOTS];
   logic [REQ_W-1:0]  target_id;
   grant_type         pending_grants [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int gap_pct        = 0;   // chance in percent of holding start low per cycle
   logic [TIME_W-1:0] now_t = '0;   // sender's running arrival clock

   always #4 clock = ~clock;

   lowest_free_slot_allocator_top dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_requester   (req_requester),
      .req_arrive_time (req_arrive_time),
      .req_leave_time  (req_leave_time),
      .rsp_valid       (rsp_valid),
      .rsp_slot        (rsp_slot),
      .rsp_is_target   (rsp_is_target),
      .rsp_full_res    (rsp_full_res),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   // lowest slot whose release time is at or before the arrival wins;
   // with nothing free the grant reports full and the slot table is untouched
   function automatic void predict_grant(input logic [REQ_W-1:0]  rq,
                                         input logic [TIME_W-1:0] arrive,
                                         input logic [TIME_W-1:0] leave);
      grant_type g;
      g.slot      = '0;
      g.full_res  = 1'b1;
      g.is_target = (rq == target_id);
      for (int s = 0; s < NUM_SLOTS; s++) begin
         if (g.full_res && slot_release[s] <= arrive) begin
            g.slot      = SLOT_OUT_W'(s);
            g.full_res  = 1'b0;
            slot_release[s] = leave;
         end
      end
      pending_grants.insert(pending_grants.size(), g);
   endfunction

   // one arrival transfer; start stays high after the transfer so that
   // back-to-back items need a single assignment per edge
   task automatic send_arrival(input logic [REQ_W-1:0]  rq,
                               input logic [TIME_W-1:0] arrive,
                               input logic [TIME_W-1:0] leave);
      while ($urandom_range(0, 99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_requester   <= rq;
      req_arrive_time <= arrive;
      req_leave_time  <= leave;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_grant(rq, arrive, leave);
   endtask

   // drop start and wait until every grant is back and the scan has stopped
   task automatic wait_quiet();
      start <= 1'b0;
      @(posedge clock);
      while (pending_grants.size() != 0 || busy) @(posedge clock);
   endtask

   // target register is only written with the block idle
   task automatic write_target(input logic [REQ_W-1:0] value);
      wait_quiet();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      target_id = value;
      csr_we    <= 1'b0;
   endtask

   function automatic logic [REQ_W-1:0] pick_requester();
      // a quarter of the arrivals come from the target
      if ($urandom_range(0, 3) == 0) return target_id;
      return REQ_W'($urandom_range(0, 65535));
   endfunction

   // boundary times: arrival at zero, at all ones, equal to release,
   // leave not after arrival, and an arrival earlier than the one before
   task automatic test_corner_times();
      send_arrival(16'h0000, 32'h0000_0000, 32'hFFFF_FFFF);  // slot 0 held to the end of time
      send_arrival(16'hFFFF, 32'h0000_0000, 32'h0000_0000);  // fresh slot still free at zero
      send_arrival(16'h0001, 32'hFFFF_FFFF, 32'h0000_0000);  // every slot free at max arrival
      send_arrival(16'h0002, 32'd100, 32'd40);               // leave before arrival
      send_arrival(16'h0003, 32'd100, 32'd200);              // same slot free again at once
      send_arrival(16'h0004, 32'd150, 32'd300);
      send_arrival(16'h0005, 32'd10,  32'd20);               // arrival out of order
      send_arrival(16'h0006, 32'd200, 32'd250);              // release equal to arrival
      send_arrival(16'h0007, 32'd200, 32'd200);              // zero-length stay
      send_arrival(16'h0008, 32'd200, 32'd201);
   endtask

   // target match and mismatch at both ends of the requester range
   task automatic test_target_match();
      write_target(16'hFFFF);
      send_arrival(16'hFFFF, 32'd400, 32'd410);
      send_arrival(16'h0000, 32'd400, 32'd420);
      send_arrival(16'hFFFE, 32'd405, 32'd430);
      write_target(16'h0000);
      send_arrival(16'h0000, 32'd500, 32'd510);
      send_arrival(16'h8000, 32'd500, 32'd510);
      write_target(REQ_W'($urandom_range(1, 65534)));
      send_arrival(target_id, 32'd600, 32'd700);
      send_arrival(~target_id, 32'd600, 32'd700);
   endtask

   // every slot taken up to the highest, then full grants that change nothing
   task automatic test_full_pool();
      logic [TIME_W-1:0] far_t;
      now_t = 32'd10_000;
      far_t = now_t + 32'd1_000_000;
      for (int i = 0; i < NUM_SLOTS + 4; i++) begin
         now_t = now_t + $urandom_range(0, 2);
         send_arrival(pick_requester(), now_t, far_t + $urandom_range(0, 1_000_000));
      end
      // past every stay: the whole pool comes free
      now_t = now_t + 32'd3_000_000;
   endtask

   // segments of in-order arrivals with random stay lengths, so occupancy
   // swings from nearly empty to full; a tenth of the items are noise
   task automatic test_random_traffic(input int pct, input int n_items,
                                      input logic [TIME_W-1:0] epoch_jump);
      int sent;
      int seg_left;
      int stay_max;
      logic [TIME_W-1:0] arrive;
      logic [TIME_W-1:0] leave;
      gap_pct  = pct;
      now_t    = now_t + epoch_jump;
      sent     = 0;
      seg_left = 0;
      stay_max = 8;
      while (sent < n_items) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(4, 40);
            case ($urandom_range(0, 3))
               0: stay_max = 8;
               1: stay_max = 64;
               2: stay_max = 400;
               default: stay_max = 4000;
            endcase
            now_t = now_t + $urandom_range(0, 5000);
         end
         if ($urandom_range(0, 9) == 0) begin
            // noise: wild or slightly stale arrival, short enough stay to not clog the pool
            if ($urandom_range(0, 1) == 0) arrive = $urandom();
            else arrive = now_t - $urandom_range(0, 50);
            leave = $urandom_range(0, now_t);
         end else begin
            now_t  = now_t + $urandom_range(0, 3);
            arrive = now_t;
            leave  = now_t + $urandom_range(0, stay_max);
         end
         send_arrival(pick_requester(), arrive, leave);
         seg_left--;
         sent++;
      end
   endtask

   // response checker: each strobe is compared with the oldest prediction
   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_valid) begin
         if (pending_grants.size() == 0) begin
            $display("%0t: unexpected transfer slot=%0d is_target=%0b full=%0b",
                     $time, rsp_slot, rsp_is_target, rsp_full_res);
            mismatch_count++;
         end else begin
            want = pending_grants.pop_front();
            if (rsp_slot !== want.slot) begin
               $display("%0t: slot expected %0d actual %0d", $time, want.slot, rsp_slot);
               mismatch_count++;
            end
            if (rsp_is_target !== want.is_target) begin
               $display("%0t: is_target expected %0b actual %0b",
                        $time, want.is_target, rsp_is_target);
               mismatch_count++;
            end
            if (rsp_full_res !== want.full_res) begin
               $display("%0t: full_res expected %0b actual %0b",
                        $time, want.full_res, rsp_full_res);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      for (int s = 0; s < NUM_SLOTS; s++) slot_release[s] = '0;
      target_id = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_target(16'h0000);
      test_corner_times();
      test_target_match();
      test_full_pool();

      // sender gaps at 30 percent, then 72, then back to back
      write_target(REQ_W'($urandom_range(0, 65535)));
      test_random_traffic(30, 140, 32'd0);
      write_target(16'hFFFF);
      test_random_traffic(72, 140, 32'h4000_0000);
      write_target(REQ_W'($urandom_range(0, 65535)));
      test_random_traffic(0, 135, 32'h4000_0000);

      wait_quiet();
      repeat (NUM_SLOTS + 8) @(posedge clock);
      if (mismatch_count == 0 && pending_grants.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/lfsa_pkg.sv
rtl/core/lfsa_ram.sv
rtl/core/lfsa_dp.sv
rtl/core/lfsa_ctrl.sv
rtl/core/lowest_free_slot_allocator_top.sv
sim/tb_top.sv
